FILE: rtl/usan_pkg.sv
package usan_pkg;

  localparam int ByteWidth  = 8;
  localparam int MaxResults = 4;
  localparam int HeldDepth  = 3;
  localparam int CountWidth = $clog2(MaxResults + 1);

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContBits  = 8'h80;
  localparam logic [7:0] AsciiTop  = 8'h80;
  localparam logic [2:0] Lead2Tag  = 3'd6;
  localparam logic [3:0] Lead3Tag  = 4'd14;
  localparam logic [4:0] Lead4Tag  = 5'd30;

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenOne  = 3'd1;
  localparam logic [2:0] LenTwo  = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour = 3'd4;

  typedef logic [ByteWidth-1:0] byte_t;

  typedef struct packed {
    logic [HeldDepth-1:0][ByteWidth-1:0]  held;
    logic [2:0]                           exp_len;
    logic [1:0]                           held_cnt;
  } seq_state_t;

  typedef struct packed {
    logic [MaxResults-1:0][ByteWidth-1:0] bytes;
    logic [CountWidth-1:0]                count;
    logic                                 has_byte;
    logic                                 stream_end;
  } burst_t;

  function automatic logic [2:0] lead_length(input byte_t b);
    logic [2:0] len;
    begin
      len = LenNone;
      priority if (b < AsciiTop) begin
        len = LenOne;
      end else if (b[7:5] == Lead2Tag) begin
        len = LenTwo;
      end else if (b[7:4] == Lead3Tag) begin
        len = LenThree;
      end else if (b[7:3] == Lead4Tag) begin
        len = LenFour;
      end else begin
        len = LenNone;
      end
      return len;
    end
  endfunction

endpackage

FILE: rtl/usan_decode.sv
module usan_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  usan_pkg::byte_t in_byte,
  input  logic            in_last,
  output usan_pkg::burst_t burst
);
  import usan_pkg::*;

  seq_state_t st;
  seq_state_t st_next;
  logic       is_cont;
  logic [2:0] len;

  always_comb begin
    st_next = st;
    burst.bytes = {MaxResults{in_byte}};
    burst.count = '0;
    burst.has_byte = 1'b1;
    burst.stream_end = in_last;
    is_cont = (in_byte & ContMask) == ContBits;
    len = lead_length(in_byte);
    if (st.exp_len != LenNone && is_cont) begin
      if ({1'b0, st.held_cnt} + 3'd1 >= st.exp_len) begin
        for (int i = 0; i < HeldDepth; i++) begin
          burst.bytes[i] = (2'(i) < st.held_cnt) ? st.held[i] : in_byte;
        end
        burst.count = CountWidth'({1'b0, st.held_cnt} + 3'd1);
        st_next.exp_len = LenNone;
        st_next.held_cnt = '0;
      end else if (st.held_cnt < 2'(HeldDepth)) begin
        st_next.held[st.held_cnt] = in_byte;
        st_next.held_cnt = st.held_cnt + 2'd1;
      end else begin
        st_next.exp_len = LenNone;
        st_next.held_cnt = '0;
      end
    end else begin
      // broken sequence or no sequence pending: judge as a lead
      st_next.exp_len = LenNone;
      st_next.held_cnt = '0;
      if (len == LenOne) begin
        burst.count = CountWidth'(1);
      end else if (len != LenNone) begin
        st_next.held[0] = in_byte;
        st_next.held_cnt = 2'd1;
        st_next.exp_len = len;
      end
    end
    if (in_last) begin
      st_next.exp_len = LenNone;
      st_next.held_cnt = '0;
      if (burst.count == '0) begin
        burst.count = CountWidth'(1);
        burst.has_byte = 1'b0;
        burst.bytes[0] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.exp_len <= LenNone;
      st.held_cnt <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    st.exp_len == LenNone |-> st.held_cnt == '0)
    else $error("held bytes with no sequence pending");

  a_pending_bounds: assert property (@(posedge clk) disable iff (rst)
    st.exp_len != LenNone |-> st.held_cnt != '0 && {1'b0, st.held_cnt} < st.exp_len)
    else $error("pending sequence count out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && in_last |=> st.exp_len == LenNone)
    else $error("sequence still pending after end of stream");
`endif

endmodule

FILE: rtl/usan_emit.sv
module usan_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  usan_pkg::burst_t burst,
  output logic             can_load,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // out_byte
  output logic             m_tlast,   // run_last
  output logic [1:0]       m_tuser    // has_byte, stream_end
);
  import usan_pkg::*;

  logic [MaxResults-1:0][ByteWidth-1:0] buf_bytes;
  logic [CountWidth-1:0]                remaining;
  logic                                 has_byte;
  logic                                 send_end;
  logic                                 fire;
  logic                                 on_last;

  assign on_last  = remaining == CountWidth'(1);
  assign fire     = m_tvalid && m_tready;
  assign can_load = (remaining == '0) || (on_last && m_tready);
  assign m_tvalid = remaining != '0;
  assign m_tdata  = buf_bytes[0];
  assign m_tlast  = on_last;
  assign m_tuser  = {send_end && on_last, has_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= burst.count;
    end else if (fire) begin
      remaining <= remaining - CountWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_bytes <= burst.bytes;
      has_byte <= burst.has_byte;
      send_end <= burst.stream_end;
    end else if (fire) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        buf_bytes[i] <= buf_bytes[i+1];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    remaining <= CountWidth'(MaxResults))
    else $error("result count above burst size");

  a_marker_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1])
    else $error("end marker not a lone final result");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load && burst.count != '0 |=> m_tvalid)
    else $error("loaded burst not presented");
`endif

endmodule

FILE: rtl/utf8_sequence_sanitizer_core.sv
// an accepted byte waits in an input register, then its results in the result register
// throughput: one input byte per cycle while m_tready is high and each byte
// yields at most one result; a byte that completes an n-byte sequence loads n results,
// which back-pressures the input until the last of them is sent
// reset clears the input and result valid state and the pending sequence
module utf8_sequence_sanitizer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast,   // run_last
  output logic [1:0] m_tuser    // has_byte, stream_end
);
  import usan_pkg::*;

  logic   in_valid;
  byte_t  in_byte;
  logic   in_last;
  logic   can_load;
  logic   take;
  burst_t burst;

  assign take     = in_valid && can_load;
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  usan_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (in_byte),
    .in_last (in_last),
    .burst   (burst)
  );

  usan_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .burst    (burst),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
